FILE: rtl/a64icd_pkg.sv
// ----------------------------------------------------------------------------
// a64icd_pkg
// Class codes and per-group decode functions for the A64 instruction class
// decoder.
// ----------------------------------------------------------------------------
package a64icd_pkg;

    typedef logic [6:0] t_class;

    localparam t_class C_UNALLOC    = 7'd0;
    localparam t_class C_UNIMPL     = 7'd1;
    localparam t_class C_PCREL      = 7'd2;
    localparam t_class C_ADDSUB_IMM = 7'd3;
    localparam t_class C_LOGIC_SH   = 7'd4;
    localparam t_class C_ADC        = 7'd5;
    localparam t_class C_CCMP_REG   = 7'd6;
    localparam t_class C_CCMP_IMM   = 7'd7;
    localparam t_class C_CSEL       = 7'd8;
    localparam t_class C_DP2        = 7'd9;
    localparam t_class C_DP1        = 7'd10;
    localparam t_class C_ADDSUB_SH  = 7'd11;
    localparam t_class C_ADDSUB_EXT = 7'd12;
    localparam t_class C_DP3        = 7'd13;
    localparam t_class C_LOGIC_IMM  = 7'd14;
    localparam t_class C_MOVW       = 7'd15;
    localparam t_class C_BITFIELD   = 7'd16;
    localparam t_class C_EXTRACT    = 7'd17;
    localparam t_class C_B_UNCOND   = 7'd18;
    localparam t_class C_CBZ        = 7'd19;
    localparam t_class C_TBZ        = 7'd20;
    localparam t_class C_B_COND     = 7'd21;
    localparam t_class C_EXCEPT     = 7'd22;
    localparam t_class C_SYSTEM     = 7'd23;
    localparam t_class C_BR_REG     = 7'd24;
    localparam t_class C_VLDM       = 7'd25;
    localparam t_class C_VLDS       = 7'd26;
    localparam t_class C_VLDM_POST  = 7'd27;
    localparam t_class C_VLDS_POST  = 7'd28;
    localparam t_class C_LD_EXCL    = 7'd29;
    localparam t_class C_LDP_NT     = 7'd30;
    localparam t_class C_LDP_POST   = 7'd31;
    localparam t_class C_LD_LIT     = 7'd32;
    localparam t_class C_LD_UNSC    = 7'd33;
    localparam t_class C_LD_POST    = 7'd34;
    localparam t_class C_LD_PRE     = 7'd35;
    localparam t_class C_LD_REGOFF  = 7'd36;
    localparam t_class C_LDP_OFF    = 7'd37;
    localparam t_class C_LDP_PRE    = 7'd38;
    localparam t_class C_LD_UOFF    = 7'd39;
    localparam t_class C_V_TBL      = 7'd40;
    localparam t_class C_V_PERM     = 7'd41;
    localparam t_class C_V_EXT      = 7'd42;
    localparam t_class C_V_COPY     = 7'd43;
    localparam t_class C_V_3DIFF    = 7'd44;
    localparam t_class C_V_2MISC    = 7'd45;
    localparam t_class C_AES        = 7'd46;
    localparam t_class C_V_ACROSS   = 7'd47;
    localparam t_class C_V_3SAME    = 7'd48;
    localparam t_class C_V_ELEM     = 7'd49;
    localparam t_class C_V_MODIMM   = 7'd50;
    localparam t_class C_V_SHIMM    = 7'd51;
    localparam t_class C_SHA3       = 7'd52;
    localparam t_class C_S_COPY     = 7'd53;
    localparam t_class C_S_3DIFF    = 7'd54;
    localparam t_class C_S_2MISC    = 7'd55;
    localparam t_class C_SHA2       = 7'd56;
    localparam t_class C_S_PAIR     = 7'd57;
    localparam t_class C_S_3SAME    = 7'd58;
    localparam t_class C_S_ELEM     = 7'd59;
    localparam t_class C_S_SHIMM    = 7'd60;
    localparam t_class C_FP_FIXCVT  = 7'd61;
    localparam t_class C_FP_INTCVT  = 7'd62;
    localparam t_class C_FP_DP1     = 7'd63;
    localparam t_class C_FP_CMP     = 7'd64;
    localparam t_class C_FP_IMM     = 7'd65;
    localparam t_class C_FP_CCMP    = 7'd66;
    localparam t_class C_FP_DP2     = 7'd67;
    localparam t_class C_FP_CSEL    = 7'd68;
    localparam t_class C_FP_DP3     = 7'd69;

    function automatic t_class f_branch(input logic [31:0] w);
        t_class     c;
        logic [31:0] m;
        logic       bad;
        c = C_UNALLOC;
        m = w & 32'h003FF0E0;
        case (w[31:29])
            3'd0, 3'd4: c = C_B_UNCOND;
            3'd1, 3'd5: c = w[25] ? C_TBZ : C_CBZ;
            3'd2: begin
                if (!(w[25] || w[24] || (w & 32'h01000010) == 32'h00000010))
                    c = C_B_COND;
            end
            3'd6: begin
                if (!w[25] && !w[24]) begin
                    bad = w[4:2] != 3'd0 ||
                        (w & 32'h00E0001D) == 32'h00200001 ||
                        (w & 32'h00E0001D) == 32'h00400001 ||
                        (w & 32'h00E0001E) == 32'h00200002 ||
                        (w & 32'h00E0001E) == 32'h00400002 ||
                        (w & 32'h00E0001C) == 32'h00600000 ||
                        (w & 32'h00E0001C) == 32'h00800000 ||
                        (w & 32'h00E0001F) == 32'h00A00000 ||
                        (w & 32'h00C0001C) == 32'h00C00000;
                    if (!bad) c = C_EXCEPT;
                end else if (!w[25]) begin
                    bad = w[23:22] != 2'd0 || w[21:19] == 3'd4 ||
                        m == 32'h00033000 || m == 32'h003FF020 ||
                        m == 32'h003FF060 || m == 32'h003FF0E0 ||
                        (w & 32'h00388000) == 32'h00008000 ||
                        (w & 32'h0038E000) == 32'h00000000 ||
                        (w & 32'h0039E000) == 32'h00002000 ||
                        (w & 32'h003AE000) == 32'h00002000 ||
                        (w & 32'h003CE000) == 32'h00042000 ||
                        (w & 32'h003FFFC0) == 32'h000320C0 ||
                        (w & 32'h003FF100) == 32'h00032100 ||
                        (w & 32'h003FF200) == 32'h00032200 ||
                        (w & 32'h003FF400) == 32'h00032400 ||
                        (w & 32'h003FF800) == 32'h00032800 ||
                        (w & 32'h0038F000) == 32'h00005000 ||
                        (w & 32'h0038E000) == 32'h00006000;
                    if (!bad) c = C_SYSTEM;
                end else begin
                    bad = w[24] || w[20:16] != 5'h1F || w[15:10] != 6'd0 ||
                        w[4:0] != 5'd0 || w[24:21] == 4'd3 || w[24:22] == 3'd3;
                    if (!bad) c = C_BR_REG;
                end
            end
            default: c = C_UNALLOC;
        endcase
        return c;
    endfunction

    function automatic t_class f_ldst(input logic [31:0] w);
        t_class c;
        logic   reg_bad;
        logic   pair_bad;
        logic   prepost_bad;
        c = C_UNALLOC;
        reg_bad = (w & 32'h84C00000) == 32'h80C00000 ||
            (w & 32'h44800000) == 32'h44800000 ||
            (w & 32'h84800000) == 32'h84800000;
        pair_bad = w[31:30] == 2'd3 || (w & 32'hC4400000) == 32'h40000000;
        prepost_bad = (w & 32'hC4C00000) == 32'hC0800000;
        if (!w[28] && !w[29] && w[26]) begin
            // vector structure load/store
            if (!(w[31] || (!w[24] && w[21]))) begin
                if (!w[23]) begin
                    if (w[20:16] == 5'd0) c = w[24] ? C_VLDS : C_VLDM;
                end else begin
                    c = w[24] ? C_VLDS_POST : C_VLDM_POST;
                end
            end
        end else if (!w[24]) begin
            if (!w[28]) begin
                if (!w[29]) c = C_LD_EXCL;
                else if (!pair_bad) begin
                    if (w[23]) c = C_LDP_POST;
                    else if ((w & 32'hC4400000) != 32'hC0400000) c = C_LDP_NT;
                end
            end else if (!w[29]) begin
                if ((w & 32'hC4000000) != 32'hC4000000) c = C_LD_LIT;
            end else if (!reg_bad) begin
                if (!w[21]) begin
                    case (w[11:10])
                        2'd0: c = C_LD_UNSC;
                        2'd1: c = prepost_bad ? C_UNALLOC : C_LD_POST;
                        2'd2: c = C_UNIMPL;
                        default: c = prepost_bad ? C_UNALLOC : C_LD_PRE;
                    endcase
                end else if (w[11:10] == 2'd2 && w[14]) begin
                    c = C_LD_REGOFF;
                end
            end
        end else if (w[29]) begin
            if (!w[28]) begin
                if (!pair_bad) c = w[23] ? C_LDP_PRE : C_LDP_OFF;
            end else if (!reg_bad) begin
                c = C_LD_UOFF;
            end
        end
        return c;
    endfunction

    function automatic t_class f_dataproc(input logic [31:0] w);
        t_class c;
        logic   bad;
        c = C_UNALLOC;
        if (!w[24]) begin
            if (!w[28]) begin
                if ((w & 32'h80008000) != 32'h00008000) c = C_LOGIC_SH;
            end else begin
                case (w[23:21])
                    3'd0: if ((w & 32'h0000FC00) == 32'd0) c = C_ADC;
                    3'd2: begin
                        if (w[29] && (w & 32'h00000410) == 32'd0)
                            c = w[11] ? C_CCMP_IMM : C_CCMP_REG;
                    end
                    3'd4: if ((w & 32'h20000800) == 32'd0) c = C_CSEL;
                    3'd6: begin
                        if (!w[29]) begin
                            if (!w[30]) begin
                                bad = w[15] || w[15:11] == 5'd0 || w[15:12] == 4'd1 ||
                                    w[15:12] == 4'd3 || w[15:13] == 3'd3 ||
                                    (w & 32'h8000EC00) == 32'h00004C00 ||
                                    (w & 32'h8000E800) == 32'h80004000 ||
                                    (w & 32'h8000E400) == 32'h80004000;
                                if (!bad) c = C_DP2;
                            end else begin
                                bad = w[13] || w[20:16] != 5'd0 || w[15:14] != 2'd0 ||
                                    (w & 32'hA01FFC00) == 32'h00000C00 ||
                                    (w & 32'h201FF800) == 32'h00001800;
                                if (!bad) c = C_DP1;
                            end
                        end
                    end
                    default: c = C_UNALLOC;
                endcase
            end
        end else if (!w[28]) begin
            if (!w[21]) begin
                if (!(w[23:22] == 2'd3 || (w & 32'h80008000) == 32'h00008000))
                    c = C_ADDSUB_SH;
            end else if (!((w & 32'h00C00000) != 32'd0 ||
                    (w & 32'h00001400) == 32'h00001400 ||
                    (w & 32'h00001800) == 32'h00001800)) begin
                c = C_ADDSUB_EXT;
            end
        end else begin
            bad = w[30] || w[30:29] == 2'd1 ||
                (w & 32'hE0600000) == 32'h00200000 ||
                (w & 32'hE0608000) == 32'h00400000 ||
                (w & 32'h60608000) == 32'h00408000 ||
                (w & 32'h60E00000) == 32'h00E00000 ||
                (w & 32'h60E00000) == 32'h00800000 ||
                (w & 32'h60E00000) == 32'h00600000;
            if (!bad) c = C_DP3;
        end
        return c;
    endfunction

    function automatic t_class f_simd_vec(input logic [31:0] w);
        t_class c;
        c = C_UNALLOC;
        if (w[31]) c = C_UNALLOC;
        else if (!w[24]) begin
            if (!w[21]) begin
                if (!w[15]) begin
                    if (!w[10]) c = w[29] ? C_V_EXT : (w[11] ? C_V_PERM : C_V_TBL);
                    else if (w[23:22] == 2'd0) c = C_V_COPY;
                end
            end else if (w[10]) c = C_V_3SAME;
            else if (!w[11]) c = C_V_3DIFF;
            else if (w[18:17] == 2'd0) begin
                if (!w[20]) begin
                    if (!w[19]) c = C_V_2MISC;
                    else if (w[30:29] == 2'd2) c = C_AES;
                end else if (!w[19]) c = C_V_ACROSS;
            end
        end else if (!w[10]) c = C_V_ELEM;
        else if (!w[23]) c = (w[22:19] == 4'd0) ? C_V_MODIMM : C_V_SHIMM;
        return c;
    endfunction

    function automatic t_class f_simd_scl(input logic [31:0] w);
        t_class c;
        c = C_UNALLOC;
        if (!w[24]) begin
            if (!w[21]) begin
                if (!w[15]) begin
                    if (!w[10]) begin
                        if (!w[29] && !w[11]) c = C_SHA3;
                    end else if (w[23:22] == 2'd0) c = C_S_COPY;
                end
            end else if (w[10]) c = C_S_3SAME;
            else if (!w[11]) c = C_S_3DIFF;
            else if (w[18:17] == 2'd0) begin
                if (!w[20]) begin
                    if (!w[19]) c = C_S_2MISC;
                    else if (!w[29]) c = C_SHA2;
                end else if (!w[19]) c = C_S_PAIR;
            end
        end else if (!w[10]) c = C_S_ELEM;
        else if (!w[23]) c = C_S_SHIMM;
        return c;
    endfunction

    function automatic t_class f_fp(input logic [31:0] w);
        t_class      c;
        logic [31:0] m;
        logic        bad;
        c = C_UNALLOC;
        m = w & 32'hA0DF8000;
        if (!w[28]) c = f_simd_vec(w);
        else if (w[31:30] == 2'd3) c = C_UNALLOC;
        else if (w[31:30] == 2'd1) c = f_simd_scl(w);
        else if (w[29]) c = C_UNALLOC;
        else if (w[24]) begin
            if ((w & 32'hA0800000) == 32'd0) c = C_FP_DP3;
        end else if (!w[21]) begin
            bad = w[23] || w[18] || (w & 32'h80008000) == 32'd0 ||
                (w & 32'h000E0000) == 32'd0 || (w & 32'h000E0000) == 32'h000A0000 ||
                (w & 32'h00160000) == 32'd0 || (w & 32'h00160000) == 32'h00120000;
            if (!bad) c = C_FP_FIXCVT;
        end else if (w[15:10] == 6'd32) c = C_UNALLOC;
        else if (w[15:10] == 6'd0) begin
            bad = w[23:22] == 2'd3 ||
                (w & 32'h000E0000) == 32'h000A0000 || (w & 32'h000E0000) == 32'h000C0000 ||
                (w & 32'h00160000) == 32'h00120000 || (w & 32'h00160000) == 32'h00140000 ||
                (w & 32'h20C40000) == 32'h00800000 || (w & 32'h20C60000) == 32'h00840000 ||
                (w & 32'hA0C60000) == 32'h80060000 || (w & 32'hA0C60000) == 32'h00860000 ||
                (w & 32'hA0C60000) == 32'h00460000 || (w & 32'hA0CE0000) == 32'h80860000 ||
                (w & 32'hA0CE0000) == 32'h804E0000 || (w & 32'hA0CE0000) == 32'h000E0000 ||
                (w & 32'hA0D60000) == 32'h00160000 || (w & 32'hA0D60000) == 32'h80560000 ||
                (w & 32'hA0D60000) == 32'h80960000;
            if (!bad) c = C_FP_INTCVT;
        end else if (w[14:10] == 5'd16) begin
            bad = (w & 32'h80180000) != 32'd0 ||
                m == 32'h00020000 || m == 32'h00030000 || m == 32'h00068000 ||
                m == 32'h00428000 || m == 32'h00430000 || m == 32'h00468000 ||
                (w & 32'hA0D80000) == 32'h00800000 || (w & 32'hA0DE0000) == 32'h00C00000 ||
                (w & 32'hA0DF0000) == 32'h00C30000 || (w & 32'hA0DC0000) == 32'h00C40000;
            if (!bad) c = C_FP_DP1;
        end else if (w[13:10] == 4'd8) begin
            if (w[15:14] == 2'd0 && w[2:0] == 3'd0 && (w & 32'h80800000) == 32'd0)
                c = C_FP_CMP;
        end else if (w[12:10] == 3'd4) begin
            if (w[9:5] == 5'd0 && (w & 32'h80800000) == 32'd0) c = C_FP_IMM;
        end else if ((w & 32'h80800000) == 32'd0) begin
            case (w[11:10])
                2'd1: c = C_FP_CCMP;
                2'd2: begin
                    if (!(w[15:14] == 2'd3 || (w & 32'h00009000) == 32'h00009000 ||
                          (w & 32'h0000A000) == 32'h0000A000))
                        c = C_FP_DP2;
                end
                2'd3: c = C_FP_CSEL;
                default: c = C_UNALLOC;
            endcase
        end
        return c;
    endfunction

endpackage

FILE: rtl/a64icd_classify.sv
// ----------------------------------------------------------------------------
// a64icd_classify
// Combinational decode tree: top-level group select on bits 28:24, then the
// per-group pattern checks.
// ----------------------------------------------------------------------------
module a64icd_classify (
    input  logic [31:0]         i_word,
    output a64icd_pkg::t_class  o_class
);

    always_comb begin
        o_class = a64icd_pkg::C_UNALLOC;
        if (i_word[28:27] != 2'd0) begin
            case (i_word[27:24])
                4'h0: o_class = a64icd_pkg::C_PCREL;
                4'h1: o_class = i_word[23] ? a64icd_pkg::C_UNALLOC
                                           : a64icd_pkg::C_ADDSUB_IMM;
                4'h2: begin
                    if ((i_word & 32'h80400000) == 32'h00400000)
                        o_class = a64icd_pkg::C_UNALLOC;
                    else if (!i_word[23])
                        o_class = a64icd_pkg::C_LOGIC_IMM;
                    else if (i_word[30:29] != 2'd1)
                        o_class = a64icd_pkg::C_MOVW;
                end
                4'h3: begin
                    if (!((i_word & 32'h80400000) == 32'h80000000 ||
                          (i_word & 32'h80400000) == 32'h00400000 ||
                          (i_word & 32'h80008000) == 32'h00008000)) begin
                        if (!i_word[23]) begin
                            if (!((i_word & 32'h80200000) == 32'h00200000 ||
                                  (i_word & 32'h60000000) == 32'h60000000))
                                o_class = a64icd_pkg::C_BITFIELD;
                        end else if (!((i_word & 32'h60200000) == 32'h00200000 ||
                                       (i_word & 32'h60000000) != 32'd0)) begin
                            o_class = a64icd_pkg::C_EXTRACT;
                        end
                    end
                end
                4'h4, 4'h5, 4'h6, 4'h7: o_class = a64icd_pkg::f_branch(i_word);
                4'h8, 4'h9, 4'hC, 4'hD: o_class = a64icd_pkg::f_ldst(i_word);
                4'hA, 4'hB: o_class = a64icd_pkg::f_dataproc(i_word);
                default: o_class = a64icd_pkg::f_fp(i_word);
            endcase
        end
    end

endmodule

FILE: rtl/a64_instruction_class_decoder.sv
// ----------------------------------------------------------------------------
// a64_instruction_class_decoder
// Classifies one A64 instruction word per item into a class code and an
// unallocated flag.
// ----------------------------------------------------------------------------
// path: input register (r_word), decode tree, result register (r_class)
// throughput: one item per cycle while the downstream accepts; the decode tree sits between the two regs
// a full result register stalls the input only when the downstream also stalls
// reset: synchronous, active low; clears both valid flags, payload untouched
module a64_instruction_class_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] instruction_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [6:0] instr_class, [7] is_unallocated
);

    logic               r_in_vld;
    logic [31:0]        r_word;
    logic               r_out_vld;
    a64icd_pkg::t_class r_class;
    a64icd_pkg::t_class w_class;
    logic               w_adv;

    a64icd_classify u_classify (
        .i_word  (r_word),
        .o_class (w_class)
    );

    // result stage moves when empty or being drained
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv || !r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (w_adv) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_word <= s_axis_tdata;
        if (w_adv && r_in_vld) r_class <= w_class;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_class == a64icd_pkg::C_UNALLOC, r_class};

    a_flag_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7] == (m_axis_tdata[6:0] == 7'd0)))
        else $error("unallocated flag disagrees with class");

    a_class_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'd69))
        else $error("class code out of range");

    a_out_fed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_in_vld))
        else $error("result appeared without a held item");

endmodule

FILE: test/a64_instruction_class_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64_instruction_class_decoder_test
// Drives instruction words into the class decoder, predicts the class of each
// from an independent decode tree and compares every result item in order.
// ----------------------------------------------------------------------------
module a64_instruction_class_decoder_test;

    localparam int N_RANDOM = 1800;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] instruction_word
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [6:0] instr_class, [7] is_unallocated

    typedef struct packed {
        logic               unalloc;
        a64icd_pkg::t_class cls;
    } t_result;

    typedef struct {
        logic [31:0]        word;
        logic               known;
        a64icd_pkg::t_class cls;
    } t_row;

    t_result     class_queue[$];
    int          n_errors;
    logic        rx_long_hold;
    logic        stim_done;

    a64_instruction_class_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic bit eqm(logic [31:0] w, logic [31:0] msk, logic [31:0] val);
        return (w & msk) == val;
    endfunction

    function automatic a64icd_pkg::t_class pred_branch(logic [31:0] w);
        logic [31:0] m;
        m = w & 32'h003FF0E0;
        case (w[31:29])
            3'd0, 3'd4: return a64icd_pkg::C_B_UNCOND;
            3'd1, 3'd5: return w[25] ? a64icd_pkg::C_TBZ : a64icd_pkg::C_CBZ;
            3'd2: begin
                if (w[25] || w[24] || eqm(w, 32'h01000010, 32'h10))
                    return a64icd_pkg::C_UNALLOC;
                return a64icd_pkg::C_B_COND;
            end
            3'd6: begin
                if (!w[25]) begin
                    if (!w[24]) begin
                        if (w[4:2] != 3'd0 || eqm(w, 32'h00E0001D, 32'h00200001) ||
                            eqm(w, 32'h00E0001D, 32'h00400001) ||
                            eqm(w, 32'h00E0001E, 32'h00200002) ||
                            eqm(w, 32'h00E0001E, 32'h00400002) ||
                            eqm(w, 32'h00E0001C, 32'h00600000) ||
                            eqm(w, 32'h00E0001C, 32'h00800000) ||
                            eqm(w, 32'h00E0001F, 32'h00A00000) ||
                            eqm(w, 32'h00C0001C, 32'h00C00000))
                            return a64icd_pkg::C_UNALLOC;
                        return a64icd_pkg::C_EXCEPT;
                    end
                    if (w[23:22] != 2'd0) return a64icd_pkg::C_UNALLOC;
                    if (w[21:19] == 3'd4 || m == 32'h00033000 || m == 32'h003FF020 ||
                        m == 32'h003FF060 || m == 32'h003FF0E0 ||
                        eqm(w, 32'h00388000, 32'h00008000) ||
                        eqm(w, 32'h0038E000, 32'h0) ||
                        eqm(w, 32'h0039E000, 32'h00002000) ||
                        eqm(w, 32'h003AE000, 32'h00002000) ||
                        eqm(w, 32'h003CE000, 32'h00042000) ||
                        eqm(w, 32'h003FFFC0, 32'h000320C0) ||
                        eqm(w, 32'h003FF100, 32'h00032100) ||
                        eqm(w, 32'h003FF200, 32'h00032200) ||
                        eqm(w, 32'h003FF400, 32'h00032400) ||
                        eqm(w, 32'h003FF800, 32'h00032800) ||
                        eqm(w, 32'h0038F000, 32'h00005000) ||
                        eqm(w, 32'h0038E000, 32'h00006000))
                        return a64icd_pkg::C_UNALLOC;
                    return a64icd_pkg::C_SYSTEM;
                end
                if (w[24] || w[20:16] != 5'h1F || w[15:10] != 6'd0 || w[4:0] != 5'd0 ||
                    w[24:21] == 4'd3 || w[24:22] == 3'd3)
                    return a64icd_pkg::C_UNALLOC;
                return a64icd_pkg::C_BR_REG;
            end
            default: return a64icd_pkg::C_UNALLOC;
        endcase
    endfunction

    function automatic a64icd_pkg::t_class pred_ldst(logic [31:0] w);
        bit reg_bad, pair_bad, pp_bad;
        reg_bad = eqm(w, 32'h84C00000, 32'h80C00000) ||
            eqm(w, 32'h44800000, 32'h44800000) || eqm(w, 32'h84800000, 32'h84800000);
        pair_bad = w[31:30] == 2'd3 || eqm(w, 32'hC4400000, 32'h40000000);
        pp_bad = eqm(w, 32'hC4C00000, 32'hC0800000);
        if (!w[28] && !w[29] && w[26]) begin
            if (w[31] || (!w[24] && w[21])) return a64icd_pkg::C_UNALLOC;
            if (!w[23]) begin
                if (w[20:16] != 5'd0) return a64icd_pkg::C_UNALLOC;
                return w[24] ? a64icd_pkg::C_VLDS : a64icd_pkg::C_VLDM;
            end
            return w[24] ? a64icd_pkg::C_VLDS_POST : a64icd_pkg::C_VLDM_POST;
        end
        if (!w[24]) begin
            if (!w[28]) begin
                if (!w[29]) return a64icd_pkg::C_LD_EXCL;
                if (pair_bad) return a64icd_pkg::C_UNALLOC;
                if (w[23]) return a64icd_pkg::C_LDP_POST;
                return eqm(w, 32'hC4400000, 32'hC0400000) ? a64icd_pkg::C_UNALLOC
                                                          : a64icd_pkg::C_LDP_NT;
            end
            if (!w[29])
                return eqm(w, 32'hC4000000, 32'hC4000000) ? a64icd_pkg::C_UNALLOC
                                                          : a64icd_pkg::C_LD_LIT;
            if (reg_bad) return a64icd_pkg::C_UNALLOC;
            if (!w[21]) begin
                case (w[11:10])
                    2'd0: return a64icd_pkg::C_LD_UNSC;
                    2'd1: return pp_bad ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_LD_POST;
                    2'd2: return a64icd_pkg::C_UNIMPL;
                    default: return pp_bad ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_LD_PRE;
                endcase
            end
            return (w[11:10] == 2'd2 && w[14]) ? a64icd_pkg::C_LD_REGOFF
                                               : a64icd_pkg::C_UNALLOC;
        end
        if (!w[29]) return a64icd_pkg::C_UNALLOC;
        if (!w[28]) begin
            if (pair_bad) return a64icd_pkg::C_UNALLOC;
            return w[23] ? a64icd_pkg::C_LDP_PRE : a64icd_pkg::C_LDP_OFF;
        end
        return reg_bad ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_LD_UOFF;
    endfunction

    function automatic a64icd_pkg::t_class pred_dataproc(logic [31:0] w);
        if (!w[24]) begin
            if (!w[28])
                return eqm(w, 32'h80008000, 32'h8000) ? a64icd_pkg::C_UNALLOC
                                                      : a64icd_pkg::C_LOGIC_SH;
            case (w[23:21])
                3'd0: return (w[15:10] != 6'd0) ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_ADC;
                3'd2: begin
                    if (!w[29] || w[10] || w[4]) return a64icd_pkg::C_UNALLOC;
                    return w[11] ? a64icd_pkg::C_CCMP_IMM : a64icd_pkg::C_CCMP_REG;
                end
                3'd4: return (w[29] || w[11]) ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_CSEL;
                3'd6: begin
                    if (w[29]) return a64icd_pkg::C_UNALLOC;
                    if (!w[30]) begin
                        if (w[15] || w[15:11] == 5'd0 || w[15:12] == 4'd1 ||
                            w[15:12] == 4'd3 || w[15:13] == 3'd3 ||
                            eqm(w, 32'h8000EC00, 32'h00004C00) ||
                            eqm(w, 32'h8000E800, 32'h80004000) ||
                            eqm(w, 32'h8000E400, 32'h80004000))
                            return a64icd_pkg::C_UNALLOC;
                        return a64icd_pkg::C_DP2;
                    end
                    if (w[13] || w[20:16] != 5'd0 || w[15:14] != 2'd0 ||
                        eqm(w, 32'hA01FFC00, 32'h00000C00) ||
                        eqm(w, 32'h201FF800, 32'h00001800))
                        return a64icd_pkg::C_UNALLOC;
                    return a64icd_pkg::C_DP1;
                end
                default: return a64icd_pkg::C_UNALLOC;
            endcase
        end
        if (!w[28]) begin
            if (!w[21]) begin
                if (w[23:22] == 2'd3 || eqm(w, 32'h80008000, 32'h8000))
                    return a64icd_pkg::C_UNALLOC;
                return a64icd_pkg::C_ADDSUB_SH;
            end
            if (w[23:22] != 2'd0 || (w[12] && w[10]) || (w[12] && w[11]))
                return a64icd_pkg::C_UNALLOC;
            return a64icd_pkg::C_ADDSUB_EXT;
        end
        if (w[30] || w[30:29] == 2'd1 || eqm(w, 32'hE0600000, 32'h00200000) ||
            eqm(w, 32'hE0608000, 32'h00400000) || eqm(w, 32'h60608000, 32'h00408000) ||
            eqm(w, 32'h60E00000, 32'h00E00000) || eqm(w, 32'h60E00000, 32'h00800000) ||
            eqm(w, 32'h60E00000, 32'h00600000))
            return a64icd_pkg::C_UNALLOC;
        return a64icd_pkg::C_DP3;
    endfunction

    function automatic a64icd_pkg::t_class pred_vec(logic [31:0] w);
        if (w[31]) return a64icd_pkg::C_UNALLOC;
        if (!w[24]) begin
            if (!w[21]) begin
                if (w[15]) return a64icd_pkg::C_UNALLOC;
                if (!w[10]) begin
                    if (w[29]) return a64icd_pkg::C_V_EXT;
                    return w[11] ? a64icd_pkg::C_V_PERM : a64icd_pkg::C_V_TBL;
                end
                return (w[23:22] == 2'd0) ? a64icd_pkg::C_V_COPY : a64icd_pkg::C_UNALLOC;
            end
            if (w[10]) return a64icd_pkg::C_V_3SAME;
            if (!w[11]) return a64icd_pkg::C_V_3DIFF;
            if (w[18:17] != 2'd0) return a64icd_pkg::C_UNALLOC;
            if (!w[20]) begin
                if (!w[19]) return a64icd_pkg::C_V_2MISC;
                return (w[30:29] == 2'd2) ? a64icd_pkg::C_AES : a64icd_pkg::C_UNALLOC;
            end
            return w[19] ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_V_ACROSS;
        end
        if (!w[10]) return a64icd_pkg::C_V_ELEM;
        if (w[23]) return a64icd_pkg::C_UNALLOC;
        return (w[22:19] == 4'd0) ? a64icd_pkg::C_V_MODIMM : a64icd_pkg::C_V_SHIMM;
    endfunction

    function automatic a64icd_pkg::t_class pred_scalar(logic [31:0] w);
        if (!w[24]) begin
            if (!w[21]) begin
                if (w[15]) return a64icd_pkg::C_UNALLOC;
                if (!w[10])
                    return (!w[29] && !w[11]) ? a64icd_pkg::C_SHA3 : a64icd_pkg::C_UNALLOC;
                return (w[23:22] == 2'd0) ? a64icd_pkg::C_S_COPY : a64icd_pkg::C_UNALLOC;
            end
            if (w[10]) return a64icd_pkg::C_S_3SAME;
            if (!w[11]) return a64icd_pkg::C_S_3DIFF;
            if (w[18:17] != 2'd0) return a64icd_pkg::C_UNALLOC;
            if (!w[20]) begin
                if (!w[19]) return a64icd_pkg::C_S_2MISC;
                return w[29] ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_SHA2;
            end
            return w[19] ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_S_PAIR;
        end
        if (!w[10]) return a64icd_pkg::C_S_ELEM;
        return w[23] ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_S_SHIMM;
    endfunction

    function automatic a64icd_pkg::t_class pred_fp(logic [31:0] w);
        logic [31:0] m;
        m = w & 32'hA0DF8000;
        if (!w[28]) return pred_vec(w);
        if (w[31:30] == 2'd3) return a64icd_pkg::C_UNALLOC;
        if (w[31:30] == 2'd1) return pred_scalar(w);
        if (w[29]) return a64icd_pkg::C_UNALLOC;
        if (w[24])
            return ((w & 32'hA0800000) != 32'd0) ? a64icd_pkg::C_UNALLOC
                                                 : a64icd_pkg::C_FP_DP3;
        if (!w[21]) begin
            if (w[23] || w[18] || (w & 32'h80008000) == 32'd0 ||
                (w & 32'h000E0000) == 32'd0 ||
                eqm(w, 32'h000E0000, 32'h000A0000) || (w & 32'h00160000) == 32'd0 ||
                eqm(w, 32'h00160000, 32'h00120000))
                return a64icd_pkg::C_UNALLOC;
            return a64icd_pkg::C_FP_FIXCVT;
        end
        if (w[15:10] == 6'd32) return a64icd_pkg::C_UNALLOC;
        if (w[15:10] == 6'd0) begin
            if (w[23:22] == 2'd3 ||
                eqm(w, 32'h000E0000, 32'h000A0000) || eqm(w, 32'h000E0000, 32'h000C0000) ||
                eqm(w, 32'h00160000, 32'h00120000) || eqm(w, 32'h00160000, 32'h00140000) ||
                eqm(w, 32'h20C40000, 32'h00800000) || eqm(w, 32'h20C60000, 32'h00840000) ||
                eqm(w, 32'hA0C60000, 32'h80060000) || eqm(w, 32'hA0C60000, 32'h00860000) ||
                eqm(w, 32'hA0C60000, 32'h00460000) || eqm(w, 32'hA0CE0000, 32'h80860000) ||
                eqm(w, 32'hA0CE0000, 32'h804E0000) || eqm(w, 32'hA0CE0000, 32'h000E0000) ||
                eqm(w, 32'hA0D60000, 32'h00160000) || eqm(w, 32'hA0D60000, 32'h80560000) ||
                eqm(w, 32'hA0D60000, 32'h80960000))
                return a64icd_pkg::C_UNALLOC;
            return a64icd_pkg::C_FP_INTCVT;
        end
        if (w[14:10] == 5'd16) begin
            if ((w & 32'h80180000) != 32'd0 || m == 32'h00020000 || m == 32'h00030000 ||
                m == 32'h00068000 || m == 32'h00428000 || m == 32'h00430000 ||
                m == 32'h00468000 || eqm(w, 32'hA0D80000, 32'h00800000) ||
                eqm(w, 32'hA0DE0000, 32'h00C00000) || eqm(w, 32'hA0DF0000, 32'h00C30000) ||
                eqm(w, 32'hA0DC0000, 32'h00C40000))
                return a64icd_pkg::C_UNALLOC;
            return a64icd_pkg::C_FP_DP1;
        end
        if (w[13:10] == 4'd8) begin
            if (w[15:14] != 2'd0 || w[2:0] != 3'd0 || w[31] || w[23])
                return a64icd_pkg::C_UNALLOC;
            return a64icd_pkg::C_FP_CMP;
        end
        if (w[12:10] == 3'd4)
            return (w[9:5] != 5'd0 || w[31] || w[23]) ? a64icd_pkg::C_UNALLOC
                                                      : a64icd_pkg::C_FP_IMM;
        if (w[31] || w[23]) return a64icd_pkg::C_UNALLOC;
        case (w[11:10])
            2'd1: return a64icd_pkg::C_FP_CCMP;
            2'd2: begin
                if (w[15:14] == 2'd3 || (w[15] && w[12]) || (w[15] && w[13]))
                    return a64icd_pkg::C_UNALLOC;
                return a64icd_pkg::C_FP_DP2;
            end
            2'd3: return a64icd_pkg::C_FP_CSEL;
            default: return a64icd_pkg::C_UNALLOC;
        endcase
    endfunction

    function automatic a64icd_pkg::t_class predict_class(logic [31:0] w);
        if (w[28:27] == 2'd0) return a64icd_pkg::C_UNALLOC;
        case (w[27:24])
            4'h0: return a64icd_pkg::C_PCREL;
            4'h1: return w[23] ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_ADDSUB_IMM;
            4'h2: begin
                if (eqm(w, 32'h80400000, 32'h00400000)) return a64icd_pkg::C_UNALLOC;
                if (!w[23]) return a64icd_pkg::C_LOGIC_IMM;
                return (w[30:29] == 2'd1) ? a64icd_pkg::C_UNALLOC : a64icd_pkg::C_MOVW;
            end
            4'h3: begin
                if (eqm(w, 32'h80400000, 32'h80000000) ||
                    eqm(w, 32'h80400000, 32'h00400000) ||
                    eqm(w, 32'h80008000, 32'h00008000))
                    return a64icd_pkg::C_UNALLOC;
                if (!w[23]) begin
                    if (eqm(w, 32'h80200000, 32'h00200000) || w[30:29] == 2'd3)
                        return a64icd_pkg::C_UNALLOC;
                    return a64icd_pkg::C_BITFIELD;
                end
                if (eqm(w, 32'h60200000, 32'h00200000) || w[30:29] != 2'd0)
                    return a64icd_pkg::C_UNALLOC;
                return a64icd_pkg::C_EXTRACT;
            end
            4'h4, 4'h5, 4'h6, 4'h7: return pred_branch(w);
            4'h8, 4'h9, 4'hC, 4'hD: return pred_ldst(w);
            4'hA, 4'hB: return pred_dataproc(w);
            default: return pred_fp(w);
        endcase
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result r;
            if (class_queue.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(m_axis_tdata), 32'd0);
            end else begin
                r = class_queue.pop_front();
                if (m_axis_tdata[6:0] !== r.cls)
                    report_mismatch("instr_class", 32'(m_axis_tdata[6:0]), 32'(r.cls));
                if (m_axis_tdata[7] !== r.unalloc)
                    report_mismatch("is_unallocated", 32'(m_axis_tdata[7]),
                                    32'(r.unalloc));
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_result e;
            e.cls = predict_class(s_axis_tdata);
            e.unalloc = (e.cls == a64icd_pkg::C_UNALLOC);
            class_queue = {class_queue, e};
        end
    end

    // ---------------- receiver ----------------
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_long_hold) m_axis_tready <= 1'b0;
            else if (stim_done) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0) || (($time / 4000) % 3 == 0);
        end
    end

    // ---------------- sender ----------------
    task automatic send_word(input logic [31:0] w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // random words, some steered into chosen encoding groups, with random operand bits
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0: w[28:27] = 2'b00;
            1: w[31:29] = 3'b110;   // exception / system / branch to register
            2: begin
                w[31:25] = 7'b1101011;
                w[20:16] = 5'h1F;
                w[15:10] = 6'd0;
                w[4:0] = 5'd0;
            end
            3: w[28:25] = 4'b1111;  // fp and scalar simd
            4: w[28:24] = 5'b01110; // vector simd
            default: ;
        endcase
        return w;
    endfunction

    t_row dir_rows[$];
    int rows_left;

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rx_long_hold  = 1'b0;
        stim_done     = 1'b0;
        n_errors      = 0;
        dir_rows = '{
            '{32'h00000000, 1'b1, a64icd_pkg::C_UNALLOC},
            '{32'hFFFFFFFF, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'hE7FFFFFF, 1'b1, a64icd_pkg::C_UNALLOC},
            '{32'h10000000, 1'b1, a64icd_pkg::C_PCREL},
            '{32'h91000000, 1'b1, a64icd_pkg::C_ADDSUB_IMM},
            '{32'hB8400800, 1'b1, a64icd_pkg::C_UNIMPL},
            '{32'h14000000, 1'b1, a64icd_pkg::C_B_UNCOND},
            '{32'h54000000, 1'b1, a64icd_pkg::C_B_COND},
            '{32'hD4000001, 1'b1, a64icd_pkg::C_EXCEPT},
            '{32'hD503201F, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'hD61F0000, 1'b1, a64icd_pkg::C_BR_REG},
            '{32'hB4000000, 1'b1, a64icd_pkg::C_CBZ},
            '{32'h36000000, 1'b1, a64icd_pkg::C_TBZ},
            '{32'h8B000000, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h9B000000, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h1E202000, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h4E200400, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h5E200400, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h0C000000, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'hF9400000, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h12000000, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h13000000, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h1A800000, 1'b0, a64icd_pkg::C_UNALLOC},
            '{32'h80000000, 1'b1, a64icd_pkg::C_UNALLOC},
            '{32'h7FFFFFFF, 1'b0, a64icd_pkg::C_UNALLOC}
        };
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].known && predict_class(dir_rows[k].word) != dir_rows[k].cls)
                report_mismatch("table row", 32'(predict_class(dir_rows[k].word)),
                                32'(dir_rows[k].cls));
            send_word(dir_rows[k].word);
        end
        idle_gap(1);
        // receiver holds off while items keep coming: the block fills and stalls
        rx_long_hold = 1'b1;
        fork
            begin
                repeat (40) @(negedge i_clk);
                rx_long_hold = 1'b0;
            end
            repeat (10) send_word(random_word());
        join
        // sender pauses until everything has drained
        idle_gap(1);
        while (class_queue.size() != 0) @(negedge i_clk);
        rows_left = N_RANDOM;
        while (rows_left > 0) begin
            int burst;
            burst = $urandom_range(1, 30);
            while (burst > 0 && rows_left > 0) begin
                send_word(random_word());
                burst--;
                rows_left--;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (class_queue.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (n_errors == 0)
            $display("a64_instruction_class_decoder_test: done, clean");
        else
            $display("a64_instruction_class_decoder_test: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("a64_instruction_class_decoder_test: done, errors");
        $finish;
    end

endmodule
